// ===== rtl/core/cmb_pkg.sv =====
// package for the can receive mailbox: sizes, codes and request type
`default_nettype none

package cmb_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int KEY_W = 32;
    localparam int IDENT_W = 29;
    localparam int LEN_W = 4;
    localparam int PAYLOAD_W = 64;
    localparam int STAMP_W = 32;
    localparam int DATA_W = LEN_W + PAYLOAD_W + STAMP_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        CMD_FRAME = 1'b0,
        CMD_READ  = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        STATUS_READ_OK    = 3'd0,
        STATUS_NOT_FOUND  = 3'd1,
        STATUS_STORED_NEW = 3'd2,
        STATUS_UPDATED    = 3'd3,
        STATUS_DROPPED    = 3'd4
    } status_t;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_SCAN,
        BK_RESP
    } back_state_t;

    typedef struct packed
    {
        cmd_t                 cmd;
        logic [KEY_W-1:0]     key;
        logic [KEY_W-1:0]     mask;
        logic [LEN_W-1:0]     length;
        logic [PAYLOAD_W-1:0] payload;
        logic [STAMP_W-1:0]   stamp;
    } queue_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/cmb_ram.sv =====
// generic single write, single read ram with registered read data
`default_nettype none

module cmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cmb_front.sv =====
// front end: accepts requests, forms the frame key, holds a short request queue
`default_nettype none

module cmb_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          cmd,
    input  wire logic [cmb_pkg::IDENT_W-1:0]   frame_ident,
    input  wire logic                          frame_extended,
    input  wire logic                          frame_remote,
    input  wire logic [cmb_pkg::LEN_W-1:0]     frame_length,
    input  wire logic [63:0]                   frame_payload,
    input  wire logic [63:0]                   frame_time,
    input  wire logic [31:0]                   query_id,
    input  wire logic [31:0]                   query_mask,
    output logic                               q_valid,
    output cmb_pkg::queue_req_t                q_req,
    input  wire logic                          q_pop
);

    cmb_pkg::queue_req_t               req_in;
    cmb_pkg::queue_req_t               q_mem_reg [cmb_pkg::QUEUE_DEPTH];
    logic [cmb_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [cmb_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [cmb_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [cmb_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [cmb_pkg::QCNT_W-1:0]        count_reg;
    logic [cmb_pkg::QCNT_W-1:0]        count_next;
    logic                              push;

    always_comb
    begin
        req_in.cmd     = cmb_pkg::cmd_t'(cmd);
        req_in.length  = frame_length;
        req_in.payload = frame_payload;
        req_in.stamp   = frame_time[cmb_pkg::STAMP_W-1:0];
        if (cmb_pkg::cmd_t'(cmd) == cmb_pkg::CMD_READ)
        begin
            req_in.key  = query_id;
            req_in.mask = query_mask;
        end
        else
        begin
            // bit 31 remote, bit 30 standard, bit 29 zero
            req_in.key  = {frame_remote, ~frame_extended, 1'b0, frame_ident};
            req_in.mask = '1;
        end
    end

    assign busy    = (count_reg == cmb_pkg::QCNT_W'(cmb_pkg::QUEUE_DEPTH));
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_req   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + cmb_pkg::QPTR_W'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = rd_ptr_reg + cmb_pkg::QPTR_W'(1);
        end
        unique case ({push, q_pop})
            2'b10:   count_next = count_reg + cmb_pkg::QCNT_W'(1);
            2'b01:   count_next = count_reg - cmb_pkg::QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= req_in;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cmb_back.sv =====
// back end: scans the mailbox table in insertion order and carries out requests
`default_nettype none

module cmb_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_valid,
    input  wire cmb_pkg::queue_req_t             q_req,
    output logic                                 q_pop,
    output logic                                 done,
    output logic [2:0]                           status,
    output logic [cmb_pkg::KEY_W-1:0]            msg_key,
    output logic [cmb_pkg::LEN_W-1:0]            msg_length,
    output logic [cmb_pkg::PAYLOAD_W-1:0]        msg_payload,
    output logic [cmb_pkg::STAMP_W-1:0]          msg_time
);

    cmb_pkg::back_state_t                  state_reg;
    cmb_pkg::back_state_t                  state_next;
    cmb_pkg::queue_req_t                   req_reg;
    cmb_pkg::queue_req_t                   req_next;
    logic [cmb_pkg::CNT_W-1:0]             issue_reg;
    logic [cmb_pkg::CNT_W-1:0]             issue_next;
    logic                                  pend_reg;
    logic                                  pend_next;
    logic [cmb_pkg::IDX_W-1:0]             pend_idx_reg;
    logic [cmb_pkg::IDX_W-1:0]             pend_idx_next;
    logic [cmb_pkg::CNT_W-1:0]             used_reg;
    logic [cmb_pkg::CNT_W-1:0]             used_next;
    logic [cmb_pkg::TABLE_ENTRIES-1:0]     unread_reg;
    logic [cmb_pkg::KEY_W-1:0]             hit_key_reg;
    logic [cmb_pkg::KEY_W-1:0]             hit_key_next;
    logic                                  done_reg;
    logic                                  done_next;
    cmb_pkg::status_t                      status_reg;
    cmb_pkg::status_t                      status_next;
    logic [cmb_pkg::KEY_W-1:0]             key_out_reg;
    logic [cmb_pkg::KEY_W-1:0]             key_out_next;
    logic [cmb_pkg::DATA_W-1:0]            data_out_reg;
    logic [cmb_pkg::DATA_W-1:0]            data_out_next;

    logic                                  issue_lt;
    logic                                  match;
    logic                                  hit;
    logic                                  scan_end;
    logic                                  table_full;
    logic                                  unread_set;
    logic                                  unread_clr;
    logic [cmb_pkg::IDX_W-1:0]             unread_idx;

    logic                                  key_we;
    logic [cmb_pkg::IDX_W-1:0]             key_waddr;
    logic [cmb_pkg::IDX_W-1:0]             key_raddr;
    logic [cmb_pkg::KEY_W-1:0]             key_rdata;
    logic                                  data_we;
    logic [cmb_pkg::IDX_W-1:0]             data_waddr;
    logic [cmb_pkg::DATA_W-1:0]            data_wdata;
    logic [cmb_pkg::DATA_W-1:0]            data_rdata;

    cmb_ram #(
        .WIDTH (cmb_pkg::KEY_W),
        .DEPTH (cmb_pkg::TABLE_ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (req_reg.key),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    cmb_ram #(
        .WIDTH (cmb_pkg::DATA_W),
        .DEPTH (cmb_pkg::TABLE_ENTRIES)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .raddr (pend_idx_reg),
        .rdata (data_rdata)
    );

    assign issue_lt   = (issue_reg < used_reg);
    assign key_raddr  = issue_reg[cmb_pkg::IDX_W-1:0];
    assign table_full = (used_reg == cmb_pkg::CNT_W'(cmb_pkg::TABLE_ENTRIES));
    assign data_wdata = {req_reg.length, req_reg.payload, req_reg.stamp};

    always_comb
    begin
        if (req_reg.cmd == cmb_pkg::CMD_READ)
        begin
            match = unread_reg[pend_idx_reg] && ((key_rdata & req_reg.mask) == req_reg.key);
        end
        else
        begin
            match = (key_rdata == req_reg.key);
        end
    end

    assign hit      = (state_reg == cmb_pkg::BK_SCAN) && pend_reg && match;
    assign scan_end = (state_reg == cmb_pkg::BK_SCAN) && !pend_reg && !issue_lt;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cmb_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = cmb_pkg::BK_SCAN;
                end
            end
            cmb_pkg::BK_SCAN:
            begin
                if (hit && (req_reg.cmd == cmb_pkg::CMD_READ))
                begin
                    state_next = cmb_pkg::BK_RESP;
                end
                else if (hit || scan_end)
                begin
                    state_next = cmb_pkg::BK_IDLE;
                end
            end
            cmb_pkg::BK_RESP:
            begin
                state_next = cmb_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = cmb_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        q_pop         = 1'b0;
        req_next      = req_reg;
        issue_next    = issue_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        used_next     = used_reg;
        hit_key_next  = hit_key_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        key_out_next  = '0;
        data_out_next = '0;
        unread_set    = 1'b0;
        unread_clr    = 1'b0;
        unread_idx    = pend_idx_reg;
        key_we        = 1'b0;
        key_waddr     = used_reg[cmb_pkg::IDX_W-1:0];
        data_we       = 1'b0;
        data_waddr    = pend_idx_reg;
        unique case (state_reg)
            cmb_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    req_next   = q_req;
                    issue_next = '0;
                end
            end
            cmb_pkg::BK_SCAN:
            begin
                // one key read issued and one key checked per cycle
                if (issue_lt)
                begin
                    issue_next    = issue_reg + cmb_pkg::CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[cmb_pkg::IDX_W-1:0];
                end
                if (hit)
                begin
                    pend_next     = 1'b0;
                    pend_idx_next = pend_idx_reg;
                    if (req_reg.cmd == cmb_pkg::CMD_READ)
                    begin
                        unread_clr   = 1'b1;
                        hit_key_next = key_rdata;
                    end
                    else
                    begin
                        data_we     = 1'b1;
                        unread_set  = 1'b1;
                        done_next   = 1'b1;
                        status_next = cmb_pkg::STATUS_UPDATED;
                    end
                end
                else if (scan_end)
                begin
                    done_next = 1'b1;
                    if (req_reg.cmd == cmb_pkg::CMD_READ)
                    begin
                        status_next = cmb_pkg::STATUS_NOT_FOUND;
                    end
                    else if (table_full)
                    begin
                        status_next = cmb_pkg::STATUS_DROPPED;
                    end
                    else
                    begin
                        key_we      = 1'b1;
                        data_we     = 1'b1;
                        data_waddr  = used_reg[cmb_pkg::IDX_W-1:0];
                        unread_set  = 1'b1;
                        unread_idx  = used_reg[cmb_pkg::IDX_W-1:0];
                        used_next   = used_reg + cmb_pkg::CNT_W'(1);
                        status_next = cmb_pkg::STATUS_STORED_NEW;
                    end
                end
            end
            cmb_pkg::BK_RESP:
            begin
                done_next     = 1'b1;
                status_next   = cmb_pkg::STATUS_READ_OK;
                key_out_next  = hit_key_reg;
                data_out_next = data_rdata;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cmb_pkg::BK_IDLE;
            used_reg  <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        issue_reg    <= issue_next;
        pend_idx_reg <= pend_idx_next;
        hit_key_reg  <= hit_key_next;
        status_reg   <= status_next;
        key_out_reg  <= key_out_next;
        data_out_reg <= data_out_next;
        if (unread_set)
        begin
            unread_reg[unread_idx] <= 1'b1;
        end
        else if (unread_clr)
        begin
            unread_reg[unread_idx] <= 1'b0;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign msg_key     = key_out_reg;
    assign msg_length  = data_out_reg[cmb_pkg::DATA_W-1 -: cmb_pkg::LEN_W];
    assign msg_payload = data_out_reg[cmb_pkg::STAMP_W +: cmb_pkg::PAYLOAD_W];
    assign msg_time    = data_out_reg[cmb_pkg::STAMP_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/can_receive_mailbox_top.sv =====
// top level of the can receive mailbox with acceptance mask lookup
// with the back end idle, a miss scans every used entry before done; a frame that matches
// entry i ends the scan at i, and a read that matches entry i goes through the response state
// the back end works on one request at a time and takes another from the queue only when idle;
// a two-deep request queue takes requests during a scan, busy when full; no receiver stall
// reset clears the entry count, queue and control; table contents are not cleared
`default_nettype none

module can_receive_mailbox_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          cmd,
    input  wire logic [28:0]                   frame_ident,
    input  wire logic                          frame_extended,
    input  wire logic                          frame_remote,
    input  wire logic [3:0]                    frame_length,
    input  wire logic [63:0]                   frame_payload,
    input  wire logic [63:0]                   frame_time,
    input  wire logic [31:0]                   query_id,
    input  wire logic [31:0]                   query_mask,
    output logic                               done,
    output logic [2:0]                         status,
    output logic [31:0]                        msg_key,
    output logic [3:0]                         msg_length,
    output logic [63:0]                        msg_payload,
    output logic [31:0]                        msg_time
);

    logic                    q_valid;
    cmb_pkg::queue_req_t     q_req;
    logic                    q_pop;

    cmb_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .frame_ident    (frame_ident),
        .frame_extended (frame_extended),
        .frame_remote   (frame_remote),
        .frame_length   (frame_length),
        .frame_payload  (frame_payload),
        .frame_time     (frame_time),
        .query_id       (query_id),
        .query_mask     (query_mask),
        .q_valid        (q_valid),
        .q_req          (q_req),
        .q_pop          (q_pop)
    );

    cmb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_req       (q_req),
        .q_pop       (q_pop),
        .done        (done),
        .status      (status),
        .msg_key     (msg_key),
        .msg_length  (msg_length),
        .msg_payload (msg_payload),
        .msg_time    (msg_time)
    );

    a_pop_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("request taken from an empty queue");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    a_frame_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != cmb_pkg::STATUS_READ_OK)) |->
            (msg_key == '0) && (msg_length == '0) && (msg_payload == '0) && (msg_time == '0))
        else $error("non-read result carries entry data");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= 3'(cmb_pkg::STATUS_DROPPED)))
        else $error("result with undefined status");

endmodule

`default_nettype wire
